/* rtl/gnh_pkg.sv */
// shared types and constants of the geographic next-hop engine
`default_nettype none

package gnh_pkg;

  // table and field sizes
  localparam int unsigned NODES      = 32;
  localparam int unsigned IDX_W      = 5;
  localparam int unsigned ID_W       = 5;
  localparam int unsigned POS_W      = 20;
  localparam int unsigned AGE_W      = 16;
  localparam int unsigned RANGE_W    = 44;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned CFG_ADDR_W = 2;

  // datapath widths: operands, products, sums
  localparam int unsigned OPD_W = 22;
  localparam int unsigned PRD_W = 44;
  localparam int unsigned SUM_W = 46;

  // stream packing
  localparam int unsigned IN_DATA_W  = 128;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned OUT_USER_W = 3;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NODES - 1);

  // operation codes
  localparam logic [OP_W-1:0] OP_OBSERVE = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK    = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

  // route kinds
  localparam logic [KIND_W-1:0] KIND_NONE      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DIRECT    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_GREEDY    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PERIMETER = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NO_ROUTE  = 3'd4;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_OWN_ID  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_RANGE   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT = 2'd2;

  localparam logic [RANGE_W-1:0] RANGE_RESET   = 44'd16000000;
  localparam logic [AGE_W-1:0]   TIMEOUT_RESET = 16'd3;
  localparam logic [AGE_W-1:0]   AGE_MAX       = 16'hFFFF;

  // pipeline command kinds
  typedef enum logic [2:0] {
    CMD_OBSERVE,
    CMD_TICK,
    CMD_GREEDY_INIT,
    CMD_GREEDY_SCAN,
    CMD_VSEL,
    CMD_WTEST,
    CMD_BEARING_A,
    CMD_BEARING_B
  } cmd_kind_e;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_OBSERVE,
    ST_TICK,
    ST_GINIT,
    ST_GSCAN,
    ST_GDRAIN,
    ST_PVSEL,
    ST_PWTEST,
    ST_PBRG_A,
    ST_PBRG_B,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0]    own_id;
    logic [RANGE_W-1:0] range_sq;
    logic [AGE_W-1:0]   timeout;
  } cfg_t;

  typedef struct packed {
    logic             latch;
    logic             issue;
    cmd_kind_e        kind;
    logic [IDX_W-1:0] idx;
    logic             load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            direct;
    logic            greedy_found;
    logic            busy;
    logic            out_free;
  } dp_status_t;

endpackage

`default_nettype wire

/* rtl/geographic_next_hop_engine.sv */
// top level: configuration registers, controller and datapath
// a tick or a greedy query scans the table once; a perimeter query scans it once per entry,
// as the Gabriel pair test for each entry is fed through the single table read port
// one transaction at a time; the next is taken while a result waits to be read
// reset: table empty, registers at own id 0, range 16000000, timeout 3
`default_nettype none

module geographic_next_hop_engine (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // node_id, node_x, node_y, node_z, own_x, own_y, own_z, zero pad
  input  wire logic [gnh_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // operation
  input  wire logic [gnh_pkg::IN_USER_W-1:0]       s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // next_hop, neighbor_count, zero pad
  output logic [gnh_pkg::OUT_DATA_W-1:0]           m_axis_tdata,
  // route_kind
  output logic [gnh_pkg::OUT_USER_W-1:0]           m_axis_tuser,
  input  wire logic                                cfg_we_i,
  input  wire logic [gnh_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  wire logic [gnh_pkg::RANGE_W-1:0]         cfg_wdata_i
);

  gnh_pkg::cfg_t       cfg_q;
  gnh_pkg::ctrl_cmd_t  cmd;
  gnh_pkg::dp_status_t status;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_id   <= '0;
      cfg_q.range_sq <= gnh_pkg::RANGE_RESET;
      cfg_q.timeout  <= gnh_pkg::TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        gnh_pkg::CFG_OWN_ID:  cfg_q.own_id   <= cfg_wdata_i[gnh_pkg::ID_W-1:0];
        gnh_pkg::CFG_RANGE:   cfg_q.range_sq <= cfg_wdata_i;
        gnh_pkg::CFG_TIMEOUT: cfg_q.timeout  <= cfg_wdata_i[gnh_pkg::AGE_W-1:0];
        default: ;
      endcase
    end
  end

  gnh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gnh_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

`ifndef SYNTHESIS
  // no transaction is taken while the pipeline still holds work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |-> !status.busy)
    else $error("input accepted while pipeline busy");

  // a result is only loaded when the output register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> status.out_free)
    else $error("result overwritten");

  // the pipeline is never fed while the block waits for input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue |-> !s_axis_tready)
    else $error("command issued while idle");

  // a loaded result shows up on the output the cycle after
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> m_axis_tvalid)
    else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire

/* rtl/gnh_ctrl.sv */
// controller state machine sequencing table scans for each transaction
`default_nettype none

module gnh_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire gnh_pkg::dp_status_t status_i,
  output gnh_pkg::ctrl_cmd_t       cmd_o
);

  gnh_pkg::state_e state_q, state_d;
  logic [gnh_pkg::IDX_W-1:0] idx_q, idx_d;
  logic [gnh_pkg::IDX_W-1:0] w_q, w_d;

  // state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gnh_pkg::ST_IDLE;
      idx_q   <= '0;
      w_q     <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      w_q     <= w_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gnh_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = gnh_pkg::ST_DISPATCH;
      end
      gnh_pkg::ST_DISPATCH: begin
        case (status_i.op)
          gnh_pkg::OP_OBSERVE: state_d = gnh_pkg::ST_OBSERVE;
          gnh_pkg::OP_TICK:    state_d = gnh_pkg::ST_TICK;
          gnh_pkg::OP_QUERY: begin
            state_d = status_i.direct ? gnh_pkg::ST_FINISH : gnh_pkg::ST_GINIT;
          end
          default:             state_d = gnh_pkg::ST_FINISH;
        endcase
      end
      gnh_pkg::ST_OBSERVE: state_d = gnh_pkg::ST_DRAIN;
      gnh_pkg::ST_TICK: begin
        if (idx_q == gnh_pkg::IDX_LAST) state_d = gnh_pkg::ST_DRAIN;
      end
      gnh_pkg::ST_GINIT: state_d = gnh_pkg::ST_GSCAN;
      gnh_pkg::ST_GSCAN: begin
        if (idx_q == gnh_pkg::IDX_LAST) state_d = gnh_pkg::ST_GDRAIN;
      end
      gnh_pkg::ST_GDRAIN: begin
        if (!status_i.busy) begin
          state_d = status_i.greedy_found ? gnh_pkg::ST_FINISH : gnh_pkg::ST_PVSEL;
        end
      end
      gnh_pkg::ST_PVSEL: state_d = gnh_pkg::ST_PWTEST;
      gnh_pkg::ST_PWTEST: begin
        if (w_q == gnh_pkg::IDX_LAST) state_d = gnh_pkg::ST_PBRG_A;
      end
      gnh_pkg::ST_PBRG_A: state_d = gnh_pkg::ST_PBRG_B;
      gnh_pkg::ST_PBRG_B: begin
        state_d = (idx_q == gnh_pkg::IDX_LAST) ? gnh_pkg::ST_DRAIN : gnh_pkg::ST_PVSEL;
      end
      gnh_pkg::ST_DRAIN: begin
        if (!status_i.busy) state_d = gnh_pkg::ST_FINISH;
      end
      gnh_pkg::ST_FINISH: begin
        if (status_i.out_free) state_d = gnh_pkg::ST_IDLE;
      end
      default: state_d = gnh_pkg::ST_IDLE;
    endcase
  end

  // scan counters, wrapping back to zero after the last entry
  always_comb begin
    idx_d = idx_q;
    w_d   = w_q;
    case (state_q)
      gnh_pkg::ST_TICK, gnh_pkg::ST_GSCAN, gnh_pkg::ST_PBRG_B: begin
        idx_d = (idx_q == gnh_pkg::IDX_LAST) ? '0 : idx_q + 1'b1;
      end
      gnh_pkg::ST_PWTEST: begin
        w_d = (w_q == gnh_pkg::IDX_LAST) ? '0 : w_q + 1'b1;
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o.latch    = 1'b0;
    cmd_o.issue    = 1'b0;
    cmd_o.kind     = gnh_pkg::CMD_OBSERVE;
    cmd_o.idx      = idx_q;
    cmd_o.load_out = 1'b0;
    case (state_q)
      gnh_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      gnh_pkg::ST_OBSERVE: begin
        cmd_o.issue = 1'b1;
        cmd_o.kind  = gnh_pkg::CMD_OBSERVE;
      end
      gnh_pkg::ST_TICK: begin
        cmd_o.issue = 1'b1;
        cmd_o.kind  = gnh_pkg::CMD_TICK;
      end
      gnh_pkg::ST_GINIT: begin
        cmd_o.issue = 1'b1;
        cmd_o.kind  = gnh_pkg::CMD_GREEDY_INIT;
      end
      gnh_pkg::ST_GSCAN: begin
        cmd_o.issue = 1'b1;
        cmd_o.kind  = gnh_pkg::CMD_GREEDY_SCAN;
      end
      gnh_pkg::ST_PVSEL: begin
        cmd_o.issue = 1'b1;
        cmd_o.kind  = gnh_pkg::CMD_VSEL;
      end
      gnh_pkg::ST_PWTEST: begin
        cmd_o.issue = 1'b1;
        cmd_o.kind  = gnh_pkg::CMD_WTEST;
        cmd_o.idx   = w_q;
      end
      gnh_pkg::ST_PBRG_A: begin
        cmd_o.issue = 1'b1;
        cmd_o.kind  = gnh_pkg::CMD_BEARING_A;
      end
      gnh_pkg::ST_PBRG_B: begin
        cmd_o.issue = 1'b1;
        cmd_o.kind  = gnh_pkg::CMD_BEARING_B;
      end
      gnh_pkg::ST_FINISH: begin
        cmd_o.load_out = status_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/gnh_datapath.sv */
// neighbour table, four-stage distance and bearing pipeline, result register
`default_nettype none

module gnh_datapath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire gnh_pkg::cfg_t                       cfg_i,
  input  wire gnh_pkg::ctrl_cmd_t                  cmd_i,
  output gnh_pkg::dp_status_t                      status_o,
  input  wire logic [gnh_pkg::IN_DATA_W-1:0]       in_data_i,
  input  wire logic [gnh_pkg::IN_USER_W-1:0]       in_user_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [gnh_pkg::OUT_DATA_W-1:0]           out_data_o,
  output logic [gnh_pkg::OUT_USER_W-1:0]           out_user_o
);

  localparam int unsigned PW = gnh_pkg::POS_W;
  localparam int unsigned OW = gnh_pkg::OPD_W;
  localparam int unsigned MW = gnh_pkg::PRD_W;
  localparam int unsigned SW = gnh_pkg::SUM_W;
  localparam int unsigned XW = gnh_pkg::IDX_W;

  function automatic logic signed [OW-1:0] ext(input logic signed [PW-1:0] v);
    ext = OW'(v);
  endfunction

  // latched transaction
  logic [gnh_pkg::OP_W-1:0] op_q;
  logic [gnh_pkg::ID_W-1:0] id_q;
  logic signed [PW-1:0] nx_q, ny_q, nz_q, ox_q, oy_q, oz_q;
  logic direct_q;

  // table
  logic [gnh_pkg::NODES-1:0] valid_q;
  logic [gnh_pkg::CNT_W-1:0] count_q;
  logic signed [PW-1:0] mem_x [gnh_pkg::NODES];
  logic signed [PW-1:0] mem_y [gnh_pkg::NODES];
  logic signed [PW-1:0] mem_z [gnh_pkg::NODES];
  logic [gnh_pkg::AGE_W-1:0] mem_age [gnh_pkg::NODES];

  // pipeline registers
  logic p1_vld_q, p2_vld_q, p3_vld_q, p4_vld_q;
  gnh_pkg::cmd_kind_e p1_kind_q, p2_kind_q, p3_kind_q, p4_kind_q;
  logic [XW-1:0] p1_idx_q, p2_idx_q, p3_idx_q, p4_idx_q;
  logic signed [PW-1:0] p1_x_q, p1_y_q, p1_z_q;
  logic [gnh_pkg::AGE_W-1:0] p1_age_q;
  logic signed [OW-1:0] a0_q, b0_q, a1_q, b1_q, a2_q, b2_q;
  logic signed [OW-1:0] a0_d, b0_d, a1_d, b1_d, a2_d, b2_d;
  logic signed [MW-1:0] m0_q, m1_q, m2_q;
  logic signed [SW-1:0] sa_q, sb_q, sa_d, sb_d;

  // per-query search state
  logic signed [PW-1:0] v_x_q, v_y_q, v_z_q;
  logic [XW-1:0] v_idx_q;
  logic [SW-1:0] vd_q;
  logic gab_q;
  logic signed [OW-1:0] cand_vx_q, cand_vy_q;
  logic cr_pos_q, cr_neg_q;
  logic [SW-1:0] gbest_d_q;
  logic [XW-1:0] gbest_i_q;
  logic gfound_q;
  logic [XW-1:0] pbest_i_q;
  logic pfound_q, pb_half_q;
  logic signed [OW-1:0] pb_x_q, pb_y_q;

  // result register
  logic out_valid_q;
  logic [gnh_pkg::ID_W-1:0] hop_q, hop_d;
  logic [gnh_pkg::KIND_W-1:0] kind_q, kind_d;
  logic [gnh_pkg::CNT_W-1:0] cnt_out_q;

  // stage one combinational helpers
  logic signed [OW-1:0] ex, ey, ez, nx, ny, nz, ox, oy, oz;
  logic signed [OW-1:0] rx, ry, cvx, cvy;
  logic [gnh_pkg::AGE_W-1:0] age_inc;
  logic tick_hit, tick_drop;

  // action stage helpers
  logic obs_hit, obs_new;
  logic half_v, cand_first;
  logic [SW-1:0] sa_u;

  // transaction latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q     <= in_user_i;
      id_q     <= in_data_i[4:0];
      nx_q     <= in_data_i[24:5];
      ny_q     <= in_data_i[44:25];
      nz_q     <= in_data_i[64:45];
      ox_q     <= in_data_i[84:65];
      oy_q     <= in_data_i[104:85];
      oz_q     <= in_data_i[124:105];
      direct_q <= valid_q[in_data_i[4:0]];
    end
  end

  // table read, registered into stage one
  always_ff @(posedge clk_i) begin
    p1_kind_q <= cmd_i.kind;
    p1_idx_q  <= cmd_i.idx;
    p1_x_q    <= mem_x[cmd_i.idx];
    p1_y_q    <= mem_y[cmd_i.idx];
    p1_z_q    <= mem_z[cmd_i.idx];
    p1_age_q  <= mem_age[cmd_i.idx];
  end

  // stage one: vector differences and operand selection
  always_comb begin
    ex = ext(p1_x_q);
    ey = ext(p1_y_q);
    ez = ext(p1_z_q);
    nx = ext(nx_q);
    ny = ext(ny_q);
    nz = ext(nz_q);
    ox = ext(ox_q);
    oy = ext(oy_q);
    oz = ext(oz_q);
    rx = ox - nx;
    ry = oy - ny;
    if (rx == '0 && ry == '0) rx = -OW'(1);
    cvx = ext(v_x_q) - ox;
    cvy = ext(v_y_q) - oy;
    if (cvx == '0 && cvy == '0) cvx = OW'(1);
    a0_d = '0;
    a1_d = '0;
    a2_d = '0;
    case (p1_kind_q)
      gnh_pkg::CMD_OBSERVE: begin
        a0_d = nx - ox;
        a1_d = ny - oy;
        a2_d = nz - oz;
      end
      gnh_pkg::CMD_GREEDY_INIT: begin
        a0_d = ox - nx;
        a1_d = oy - ny;
        a2_d = oz - nz;
      end
      gnh_pkg::CMD_GREEDY_SCAN: begin
        a0_d = ex - nx;
        a1_d = ey - ny;
        a2_d = ez - nz;
      end
      gnh_pkg::CMD_VSEL: begin
        a0_d = ex - ox;
        a1_d = ey - oy;
        a2_d = ez - oz;
      end
      gnh_pkg::CMD_WTEST: begin
        a0_d = (ex <<< 1) - ox - ext(v_x_q);
        a1_d = (ey <<< 1) - oy - ext(v_y_q);
        a2_d = (ez <<< 1) - oz - ext(v_z_q);
      end
      default: ;
    endcase
    b0_d = a0_d;
    b1_d = a1_d;
    b2_d = a2_d;
    case (p1_kind_q)
      gnh_pkg::CMD_BEARING_A: begin
        // cross r x v, dot part r.x * v.x
        a0_d = rx;
        b0_d = cvy;
        a1_d = ry;
        b1_d = cvx;
        a2_d = rx;
        b2_d = cvx;
      end
      gnh_pkg::CMD_BEARING_B: begin
        // dot part r.y * v.y, cross v x best
        a0_d = ry;
        b0_d = cvy;
        a1_d = cvx;
        b1_d = pb_y_q;
        a2_d = cvy;
        b2_d = pb_x_q;
      end
      default: ;
    endcase
  end

  // tick ageing happens at stage one
  always_comb begin
    age_inc   = (p1_age_q == gnh_pkg::AGE_MAX) ? p1_age_q : p1_age_q + 1'b1;
    tick_hit  = p1_vld_q && (p1_kind_q == gnh_pkg::CMD_TICK) && valid_q[p1_idx_q];
    tick_drop = tick_hit && (age_inc > cfg_i.timeout);
  end

  // stages two to four: operands, products, sums
  always_ff @(posedge clk_i) begin
    p2_kind_q <= p1_kind_q;
    p2_idx_q  <= p1_idx_q;
    a0_q <= a0_d;
    b0_q <= b0_d;
    a1_q <= a1_d;
    b1_q <= b1_d;
    a2_q <= a2_d;
    b2_q <= b2_d;
    p3_kind_q <= p2_kind_q;
    p3_idx_q  <= p2_idx_q;
    m0_q <= a0_q * b0_q;
    m1_q <= a1_q * b1_q;
    m2_q <= a2_q * b2_q;
    p4_kind_q <= p3_kind_q;
    p4_idx_q  <= p3_idx_q;
    sa_q <= sa_d;
    sb_q <= sb_d;
  end

  // sum stage
  always_comb begin
    case (p3_kind_q)
      gnh_pkg::CMD_BEARING_A: begin
        sa_d = SW'(m0_q) - SW'(m1_q);
        sb_d = SW'(m2_q);
      end
      gnh_pkg::CMD_BEARING_B: begin
        sa_d = sb_q + SW'(m0_q);
        sb_d = SW'(m1_q) - SW'(m2_q);
      end
      default: begin
        sa_d = SW'(m0_q) + SW'(m1_q) + SW'(m2_q);
        sb_d = SW'(m2_q);
      end
    endcase
  end

  // action stage decisions
  always_comb begin
    sa_u    = $unsigned(sa_q);
    obs_hit = p4_vld_q && (p4_kind_q == gnh_pkg::CMD_OBSERVE) && (id_q != cfg_i.own_id) &&
              (sa_u < SW'(cfg_i.range_sq));
    obs_new = obs_hit && !valid_q[id_q];
    if (cr_pos_q) begin
      half_v = 1'b0;
    end else if (cr_neg_q) begin
      half_v = 1'b1;
    end else begin
      half_v = !(sa_q > 0);
    end
    if (!pfound_q) begin
      cand_first = 1'b1;
    end else if (half_v != pb_half_q) begin
      cand_first = !half_v;
    end else begin
      cand_first = (sb_q > 0);
    end
  end

  // table writes
  always_ff @(posedge clk_i) begin
    if (obs_hit) begin
      mem_x[id_q]   <= nx_q;
      mem_y[id_q]   <= ny_q;
      mem_z[id_q]   <= nz_q;
      mem_age[id_q] <= '0;
    end else if (tick_hit) begin
      mem_age[p1_idx_q] <= age_inc;
    end
  end

  // valid bits, entry count and stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      count_q  <= '0;
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      p3_vld_q <= 1'b0;
      p4_vld_q <= 1'b0;
    end else begin
      p1_vld_q <= cmd_i.issue;
      p2_vld_q <= p1_vld_q;
      p3_vld_q <= p2_vld_q;
      p4_vld_q <= p3_vld_q;
      if (obs_hit) valid_q[id_q] <= 1'b1;
      if (obs_new) count_q <= count_q + 1'b1;
      if (tick_drop) begin
        valid_q[p1_idx_q] <= 1'b0;
        count_q           <= count_q - 1'b1;
      end
    end
  end

  // search state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gfound_q <= 1'b0;
      pfound_q <= 1'b0;
    end else if (cmd_i.latch) begin
      gfound_q <= 1'b0;
      pfound_q <= 1'b0;
    end else if (p4_vld_q) begin
      case (p4_kind_q)
        gnh_pkg::CMD_GREEDY_SCAN: begin
          if (valid_q[p4_idx_q] && sa_u < gbest_d_q) gfound_q <= 1'b1;
        end
        gnh_pkg::CMD_BEARING_B: begin
          if (valid_q[p4_idx_q] && gab_q && cand_first) pfound_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    // current candidate, latched when its entry leaves stage one
    if (p1_vld_q && p1_kind_q == gnh_pkg::CMD_VSEL) begin
      v_x_q   <= p1_x_q;
      v_y_q   <= p1_y_q;
      v_z_q   <= p1_z_q;
      v_idx_q <= p1_idx_q;
    end
    if (p1_vld_q && p1_kind_q == gnh_pkg::CMD_BEARING_A) begin
      cand_vx_q <= cvx;
      cand_vy_q <= cvy;
    end
    if (p4_vld_q) begin
      case (p4_kind_q)
        gnh_pkg::CMD_GREEDY_INIT: gbest_d_q <= sa_u;
        gnh_pkg::CMD_GREEDY_SCAN: begin
          if (valid_q[p4_idx_q] && sa_u < gbest_d_q) begin
            gbest_d_q <= sa_u;
            gbest_i_q <= p4_idx_q;
          end
        end
        gnh_pkg::CMD_VSEL: begin
          vd_q  <= sa_u;
          gab_q <= 1'b1;
        end
        gnh_pkg::CMD_WTEST: begin
          // another neighbour inside the diametral sphere breaks the edge
          if (valid_q[p4_idx_q] && p4_idx_q != v_idx_q && p4_idx_q != cfg_i.own_id &&
              sa_u < vd_q) gab_q <= 1'b0;
        end
        gnh_pkg::CMD_BEARING_A: begin
          cr_pos_q <= (sa_q > 0);
          cr_neg_q <= (sa_q < 0);
        end
        gnh_pkg::CMD_BEARING_B: begin
          if (valid_q[p4_idx_q] && gab_q && cand_first) begin
            pbest_i_q <= p4_idx_q;
            pb_x_q    <= cand_vx_q;
            pb_y_q    <= cand_vy_q;
            pb_half_q <= half_v;
          end
        end
        default: ;
      endcase
    end
  end

  // route decision
  always_comb begin
    hop_d  = '0;
    kind_d = gnh_pkg::KIND_NONE;
    if (op_q == gnh_pkg::OP_QUERY) begin
      if (direct_q) begin
        hop_d  = id_q;
        kind_d = gnh_pkg::KIND_DIRECT;
      end else if (gfound_q) begin
        hop_d  = gbest_i_q;
        kind_d = gnh_pkg::KIND_GREEDY;
      end else if (pfound_q) begin
        hop_d  = pbest_i_q;
        kind_d = gnh_pkg::KIND_PERIMETER;
      end else begin
        kind_d = gnh_pkg::KIND_NO_ROUTE;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      hop_q     <= hop_d;
      kind_q    <= kind_d;
      cnt_out_q <= count_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {5'b0, cnt_out_q, hop_q};
  assign out_user_o  = kind_q;

  assign status_o.op           = op_q;
  assign status_o.direct       = direct_q;
  assign status_o.greedy_found = gfound_q;
  assign status_o.busy         = p1_vld_q | p2_vld_q | p3_vld_q | p4_vld_q;
  assign status_o.out_free     = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire
